// ===== hdl/sma_pkg.sv =====
// Shared types and constants for the simple moving average filter.
// No dependencies; imported by sma_div and simple_moving_average.
package sma_pkg;

    // Ring depth and field widths
    localparam int MAX_WINDOW  = 256;
    localparam int SAMPLE_BITS = 16;
    localparam int SLOT_BITS   = $clog2(MAX_WINDOW);
    localparam int WIN_BITS    = SLOT_BITS + 1;
    localparam int SUM_BITS    = SAMPLE_BITS + SLOT_BITS;

    // Divider: one quotient bit per step
    localparam int DIV_STEPS = SUM_BITS;
    localparam int CNT_BITS  = $clog2(DIV_STEPS);

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_DIV,
        ST_OUT
    } sma_state_t;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } sma_div_stat_t;

endpackage

// ===== hdl/sma_div.sv =====
// Iterative restoring divider: signed window sum by unsigned window size.
// One quotient bit per cycle, quotient truncated toward zero. Uses sma_pkg.
module sma_div
    import sma_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic signed [SUM_BITS-1:0] dividend,
    input  logic        [WIN_BITS-1:0] divisor,
    output sma_div_stat_t              stat,
    output logic signed [SUM_BITS-1:0] quotient
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic [WIN_BITS-1:0] rem_reg, rem_next;
    logic [SUM_BITS-1:0] shift_reg, shift_next;
    logic [WIN_BITS-1:0] dvs_reg, dvs_next;
    logic                neg_reg, neg_next;

    logic [WIN_BITS:0]   trial;
    logic [WIN_BITS:0]   diff;
    logic                fits;

    // Trial subtract of the divisor from the shifted partial remainder
    assign trial = {rem_reg, shift_reg[SUM_BITS-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    // Next state of the shift-and-subtract loop
    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        shift_next = shift_reg;
        dvs_next   = dvs_reg;
        neg_next   = neg_reg;
        if (start) begin
            busy_next  = 1'b1;
            count_next = '0;
            rem_next   = '0;
            dvs_next   = divisor;
            neg_next   = dividend[SUM_BITS-1];
            shift_next = dividend[SUM_BITS-1] ? (~dividend + 1'b1) : dividend;
        end else if (busy_reg) begin
            rem_next   = fits ? diff[WIN_BITS-1:0] : trial[WIN_BITS-1:0];
            shift_next = {shift_reg[SUM_BITS-2:0], fits};
            count_next = count_reg + 1'b1;
            if (count_reg == CNT_BITS'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
        dvs_reg   <= dvs_next;
        neg_reg   <= neg_next;
    end

    // Restore the sign of the quotient
    assign quotient  = neg_reg ? signed'(~shift_reg + 1'b1) : signed'(shift_reg);
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== hdl/simple_moving_average.sv =====
// Top level of the simple moving average (boxcar) filter over Q8.8 samples.
// Depends on sma_pkg and sma_div.
//
// Each sample beat yields one result beat: the sum of the last window_size samples
// divided by window_size, truncated toward zero; m_average_valid stays low (and
// m_average zero) until window_size samples have arrived since the last write of
// window_size. A write of window_size, even of the same value, restarts the window;
// zero is taken as 1 and values above 256 as 256. Samples sit in a 256-entry ring
// memory with a running 24-bit sum. Once the window is full an item passes through a
// ring read, sum update, 24 steps of the one-bit-per-cycle divider and result hand-off;
// while the window fills the divider is skipped. No new sample is taken before hand-off.
// A finished result waits in the output register while the next sample is taken.
module simple_moving_average
    import sma_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic        [WIN_BITS-1:0]    cfg_window_size,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_average,
    output logic                          m_average_valid
);

    sma_state_t state_reg, state_next;

    logic [WIN_BITS-1:0]           win_reg, win_next;
    logic [SLOT_BITS-1:0]          wslot_reg, wslot_next;
    logic signed [SUM_BITS-1:0]    sum_reg, sum_next;
    logic [WIN_BITS-1:0]           fill_reg, fill_next;
    logic                          m_valid_reg, m_valid_next;

    logic [SLOT_BITS-1:0]          slot_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [SAMPLE_BITS-1:0] ring_rdata_reg;
    logic signed [SAMPLE_BITS-1:0] res_avg_reg;
    logic                          res_vld_reg;
    logic signed [SAMPLE_BITS-1:0] m_average_reg;
    logic                          m_average_valid_reg;

    logic signed [SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];

    logic                          s_fire, cfg_fire, out_free;
    logic                          ring_we, div_start, res_zero, res_div, m_load;
    logic [SLOT_BITS-1:0]          slot_eff;
    logic [WIN_BITS-1:0]           slot_inc;
    logic                          full_pre;
    logic signed [SUM_BITS-1:0]    old_ext, new_ext;
    logic [WIN_BITS-1:0]           win_cfg;

    sma_div_stat_t                 div_stat;
    logic signed [SUM_BITS-1:0]    div_quo;

    assign s_fire   = s_valid && s_ready;
    assign cfg_fire = cfg_valid && cfg_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Slot to use now and the one after it
    assign slot_eff = ({1'b0, wslot_reg} >= win_reg) ? '0 : wslot_reg;
    assign slot_inc = {1'b0, slot_reg} + 1'b1;
    assign full_pre = (fill_reg >= win_reg);

    // Sign-extend the outgoing and incoming samples to sum width
    assign old_ext = {{(SUM_BITS-SAMPLE_BITS){ring_rdata_reg[SAMPLE_BITS-1]}}, ring_rdata_reg};
    assign new_ext = {{(SUM_BITS-SAMPLE_BITS){sample_reg[SAMPLE_BITS-1]}}, sample_reg};

    // Clamp a written window size to 1..MAX_WINDOW
    always_comb begin
        if (cfg_window_size == '0) begin
            win_cfg = WIN_BITS'(1);
        end else if (cfg_window_size > WIN_BITS'(MAX_WINDOW)) begin
            win_cfg = WIN_BITS'(MAX_WINDOW);
        end else begin
            win_cfg = cfg_window_size;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_SUM;
            end
            ST_SUM: begin
                state_next = (fill_reg >= win_reg) ? ST_DIV : ST_OUT;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_ready   = 1'b0;
        cfg_ready = 1'b0;
        ring_we   = 1'b0;
        div_start = 1'b0;
        res_zero  = 1'b0;
        res_div   = 1'b0;
        m_load    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                cfg_ready = 1'b1;
            end
            ST_READ: begin
                ring_we = 1'b1;
            end
            ST_SUM: begin
                div_start = (fill_reg >= win_reg);
                res_zero  = (fill_reg <  win_reg);
            end
            ST_DIV: begin
                res_div = div_stat.done;
            end
            ST_OUT: begin
                m_load = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Window bookkeeping: running sum, fill count, write slot
    always_comb begin
        win_next   = win_reg;
        wslot_next = wslot_reg;
        sum_next   = sum_reg;
        fill_next  = fill_reg;
        if (cfg_fire) begin
            win_next   = win_cfg;
            wslot_next = '0;
            sum_next   = '0;
            fill_next  = '0;
        end else if (ring_we) begin
            sum_next   = sum_reg - (full_pre ? old_ext : '0) + new_ext;
            fill_next  = full_pre ? fill_reg : fill_reg + 1'b1;
            wslot_next = (slot_inc >= win_reg) ? '0 : slot_inc[SLOT_BITS-1:0];
        end
    end

    // Output register valid: set on load, drop when taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_load) begin
            m_valid_next = 1'b1;
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            win_reg     <= WIN_BITS'(1);
            wslot_reg   <= '0;
            sum_reg     <= '0;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            win_reg     <= win_next;
            wslot_reg   <= wslot_next;
            sum_reg     <= sum_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Capture the sample beat and its slot; a window write in the same beat restarts at slot 0
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            sample_reg <= s_sample;
            slot_reg   <= cfg_fire ? '0 : slot_eff;
        end
    end

    // Ring memory: write the new sample, read the one it replaces
    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[slot_reg] <= sample_reg;
        end
        ring_rdata_reg <= ring_mem[slot_eff];
    end

    // Hold the finished result, then move it into the output register
    always_ff @(posedge aclk) begin
        if (res_zero) begin
            res_avg_reg <= '0;
            res_vld_reg <= 1'b0;
        end else if (res_div) begin
            res_avg_reg <= div_quo[SAMPLE_BITS-1:0];
            res_vld_reg <= 1'b1;
        end
        if (m_load) begin
            m_average_reg       <= res_avg_reg;
            m_average_valid_reg <= res_vld_reg;
        end
    end

    sma_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (win_reg),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    assign m_valid         = m_valid_reg;
    assign m_average       = m_average_reg;
    assign m_average_valid = m_average_valid_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= win_reg)
        else $error("fill count exceeds window size");

    a_slot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, wslot_reg} < win_reg)
        else $error("write slot outside window");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside divide state");

    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_average_valid_reg) |-> (m_average_reg == '0))
        else $error("invalid result carries nonzero average");
`endif

endmodule

// ===== sim/simple_moving_average_tb.sv =====
// Self-checking testbench for simple_moving_average: random and directed Q8.8 sample beats,
// checked against an in-bench boxcar predictor across several window_size settings.
// Depends on sma_pkg and the simple_moving_average RTL.
`timescale 1ns / 100ps

module simple_moving_average_tb;
    import sma_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 600;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] average;
        logic                          full;
    } average_beat_t;

    typedef enum int {
        MIX_RANDOM,
        MIX_MIN,
        MIX_MAX
    } sample_mix_t;

    logic                aclk            = 1'b0;
    logic                aresetn         = 1'b0;
    logic                cfg_valid       = 1'b0;
    logic                cfg_ready;
    logic [WIN_BITS-1:0] cfg_window_size = '0;
    logic                s_valid         = 1'b0;
    logic                s_ready;
    sample_t             s_sample        = '0;
    logic                m_valid;
    logic                m_ready         = 1'b0;
    sample_t             m_average;
    logic                m_average_valid;

    // Pending sample beats and averages still owed by the block
    sample_t       sample_queue[$];
    average_beat_t expected_averages[$];

    // Boxcar predictor state
    sample_t               ring_copy[MAX_WINDOW];
    logic [SLOT_BITS-1:0]  ring_slot    = '0;
    logic signed [SUM_BITS-1:0] running_sum = '0;
    logic [WIN_BITS-1:0]   held_count   = '0;
    logic [WIN_BITS-1:0]   window_reg   = WIN_BITS'(1);

    // Traffic shaping, written by the sequence at falling edges
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_requests  = 0;

    int unsigned error_count    = 0;
    int unsigned samples_sent   = 0;
    int unsigned results_seen   = 0;
    int unsigned full_results   = 0;
    int unsigned window_writes  = 0;
    int unsigned cycle_count    = 0;

    simple_moving_average uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_window_size (cfg_window_size),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample        (s_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_average       (m_average),
        .m_average_valid (m_average_valid)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Clamp the programmed size into 1..MAX_WINDOW
    function automatic int unsigned active_window();
        if (window_reg == '0) return 1;
        if (window_reg > MAX_WINDOW) return MAX_WINDOW;
        return window_reg;
    endfunction

    // Advance the boxcar by one sample and queue the average it owes
    function automatic void predict_average(input sample_t smp);
        int unsigned   win;
        int unsigned   slot;
        longint        quotient;
        average_beat_t beat;
        win  = active_window();
        slot = (ring_slot >= win) ? 0 : ring_slot;
        if (held_count >= win) running_sum -= ring_copy[slot];
        ring_copy[slot] = smp;
        running_sum += smp;
        slot++;
        ring_slot = (slot >= win) ? '0 : SLOT_BITS'(slot);
        if (held_count < win) held_count++;
        beat = '0;
        if (held_count >= win) begin
            quotient     = longint'(running_sum) / longint'(win);
            beat.average = quotient[SAMPLE_BITS-1:0];
            beat.full    = 1'b1;
        end
        expected_averages.push_back(beat);
    endfunction

    function automatic sample_t pick_sample(input sample_mix_t mix);
        int unsigned roll;
        roll = $urandom_range(99);
        case (mix)
            MIX_MIN: return sample_t'(-32768);
            MIX_MAX: return sample_t'(32767);
            default: begin
                if (roll < 15) return roll[0] ? sample_t'(32767) : sample_t'(-32768);
                if (roll < 35) return sample_t'(int'($urandom_range(600)) - 300);
                return sample_t'($urandom());
            end
        endcase
    endfunction

    // Feed sample beats, predict on every accepted beat, follow window writes
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                window_reg  = cfg_window_size;
                ring_slot   = '0;
                running_sum = '0;
                held_count  = '0;
                window_writes++;
            end
            if (s_valid && s_ready) begin
                predict_average(s_sample);
                samples_sent++;
            end
            if (!s_valid || s_ready) begin
                if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid  <= 1'b1;
                    s_sample <= sample_queue.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Drive result-side backpressure, with a long hold-off on request
    int unsigned hold_left   = 0;
    int unsigned hold_served = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Check each result beat against the oldest predicted average
    always @(posedge aclk) begin
        average_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_averages.size() == 0) begin
                $display("%0t: unexpected result beat average=%0d valid=%0b",
                         $time, m_average, m_average_valid);
                error_count++;
            end else begin
                want = expected_averages.pop_front();
                if (want.full) full_results++;
                if (m_average !== want.average) begin
                    $display("%0t: average mismatch expected %0d actual %0d",
                             $time, want.average, m_average);
                    error_count++;
                end
                if (m_average_valid !== want.full) begin
                    $display("%0t: average_valid mismatch expected %0b actual %0b",
                             $time, want.full, m_average_valid);
                    error_count++;
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_window(input logic [WIN_BITS-1:0] win_size);
        @(posedge aclk);
        cfg_valid       <= 1'b1;
        cfg_window_size <= win_size;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_samples(input sample_mix_t mix, input int count);
        @(negedge aclk);
        repeat (count) sample_queue.push_back(pick_sample(mix));
    endtask

    // Wait for every beat to go through, then let the block settle
    task automatic drain();
        while (sample_queue.size() != 0 || s_valid || expected_averages.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
        @(negedge aclk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset window of 1, field extremes
        @(negedge aclk);
        sample_queue = '{sample_t'(32767), sample_t'(-32768), sample_t'(0), sample_t'(-1)};
        drain();

        // Zero window acts as one
        write_window('0);
        @(negedge aclk);
        sample_queue = '{sample_t'(1), sample_t'(-2)};
        drain();

        // Window of 3: extreme sums, then truncation toward zero on negative means
        write_window(WIN_BITS'(3));
        @(negedge aclk);
        sample_queue = '{sample_t'(-32768), sample_t'(-32768), sample_t'(-32768),
                         sample_t'(32767), sample_t'(32767), sample_t'(32767),
                         sample_t'(-5), sample_t'(0), sample_t'(0)};
        drain();

        // Same value again must restart the fill
        write_window(WIN_BITS'(3));
        @(negedge aclk);
        sample_queue = '{sample_t'(-1), sample_t'(-1), sample_t'(1)};
        drain();

        write_window(WIN_BITS'(2));
        @(negedge aclk);
        sample_queue = '{sample_t'(32767), sample_t'(-32768)};
        drain();

        // No idling: full 256 window at the most negative sum, long result hold-off
        set_idling(0, 0);
        write_window(WIN_BITS'(256));
        queue_samples(MIX_MIN, 256);
        queue_samples(MIX_RANDOM, 44);
        @(negedge aclk);
        hold_requests++;
        drain();

        // Sparse sender: oversized window clamps to the maximum
        set_idling(71, 0);
        write_window(WIN_BITS'(511));
        queue_samples(MIX_RANDOM, 270);
        drain();
        write_window('0);
        queue_samples(MIX_RANDOM, 30);
        drain();

        // Stalling receiver: tiny window, then just over the maximum at the top sum
        set_idling(0, 71);
        write_window(WIN_BITS'(2));
        queue_samples(MIX_RANDOM, 60);
        drain();
        write_window(WIN_BITS'(257));
        queue_samples(MIX_MAX, 256);
        queue_samples(MIX_RANDOM, 14);
        drain();

        // Both sides idling: assorted small windows, then one anywhere in the field's 0..511 range
        set_idling(38, 38);
        repeat (5) begin
            write_window(WIN_BITS'($urandom_range(40, 1)));
            queue_samples(MIX_RANDOM, 40);
            drain();
        end
        write_window(WIN_BITS'($urandom_range(511)));
        queue_samples(MIX_RANDOM, 30);
        drain();

        if (expected_averages.size() != 0) begin
            $display("%0t: %0d averages never arrived", $time, expected_averages.size());
            error_count++;
        end
        $display("Sent %0d samples over %0d window writes; checked %0d averages, %0d full.",
                 samples_sent, window_writes, results_seen, full_results);
        $display("Idling phases: none, sparse sender, stalling receiver, both; errors: %0d",
                 error_count);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
